>>> rtl/core/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median unit
// Default sizes, configuration register layout and the per-cell control word.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int         CFG_W     = 7;
    localparam logic [6:0] LEN_RESET = 7'd3;

    // broadcast to every cell of the sorted row
    typedef struct packed {
        logic load;   // a sample transaction is taken this cycle
        logic evict;  // window is full, oldest entry leaves
        logic clear;  // empty the row
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/core/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window row
// Holds one value with its age. On each taken sample it closes the gap left by the
// evicted entry, if any, and opens a gap for the new sample, using its neighbors.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AGE_W        = 6
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire swm_pkg::t_cell_ctl  i_ctl,
    input  wire  [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire  [SAMPLE_WIDTH-1:0]  i_vkey,
    input  wire  [AGE_W-1:0]         i_age_last,
    // left neighbor after compaction
    input  wire  [SAMPLE_WIDTH-1:0]  i_left_value,
    input  wire  [AGE_W-1:0]         i_left_age,
    input  wire                      i_left_valid,
    input  wire                      i_left_gt,
    // right neighbor as stored
    input  wire  [SAMPLE_WIDTH-1:0]  i_right_value,
    input  wire  [AGE_W-1:0]         i_right_age,
    input  wire                      i_right_valid,
    output logic [SAMPLE_WIDTH-1:0]  o_value,
    output logic [AGE_W-1:0]         o_age,
    output logic                     o_valid,
    output logic [SAMPLE_WIDTH-1:0]  o_c_value,
    output logic [AGE_W-1:0]         o_c_age,
    output logic                     o_c_valid,
    output logic                     o_gt,
    output logic                     o_victim
);

    logic [SAMPLE_WIDTH-1:0] r_value, n_value;
    logic [AGE_W-1:0]        r_age, n_age;
    logic                    r_valid, n_valid;
    logic                    shift;

    always_comb begin
        // at or after the victim: equal keys sit behind it since it is the oldest
        shift = i_ctl.evict && (!r_valid || ($signed(r_value) >= $signed(i_vkey)));
        if (shift) begin
            o_c_value = i_right_value;
            o_c_age   = i_right_age;
            o_c_valid = i_right_valid;
        end else begin
            o_c_value = r_value;
            o_c_age   = r_age;
            o_c_valid = r_valid;
        end
        o_gt = !o_c_valid || ($signed(o_c_value) > $signed(i_sample));

        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.load) begin
            if (o_gt && !i_left_gt) begin
                n_value = i_sample;
                n_age   = '0;
                n_valid = 1'b1;
            end else if (o_gt) begin
                n_value = i_left_value;
                n_age   = i_left_age + AGE_W'(1);
                n_valid = i_left_valid;
            end else begin
                n_value = o_c_value;
                n_age   = o_c_age + AGE_W'(1);
                n_valid = o_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value  = r_value;
    assign o_age    = r_age;
    assign o_valid  = r_valid;
    assign o_victim = r_valid && (r_age == i_age_last);

endmodule
`default_nettype wire

>>> rtl/core/swm_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_chain: row of sorted window cells
// Links the cells to their neighbors, finds the value of the oldest entry
// and picks the entry at the median position.
// ----------------------------------------------------------------------------
module swm_chain #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int IDX_W        = 6
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire swm_pkg::t_cell_ctl  i_ctl,
    input  wire  [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire  [IDX_W-1:0]         i_age_last,
    input  wire  [IDX_W-1:0]         i_mid,
    output logic [SAMPLE_WIDTH-1:0]  o_median
);

    logic [SAMPLE_WIDTH-1:0] value   [WINDOW_MAX+1];
    logic [IDX_W-1:0]        age     [WINDOW_MAX+1];
    logic                    valid   [WINDOW_MAX+1];
    logic [SAMPLE_WIDTH-1:0] c_value [WINDOW_MAX];
    logic [IDX_W-1:0]        c_age   [WINDOW_MAX];
    logic                    c_valid [WINDOW_MAX];
    logic                    gt      [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   victim;
    logic [SAMPLE_WIDTH-1:0] vkey;

    // slot past the last cell is always empty
    assign value[WINDOW_MAX]   = '0;
    assign age[WINDOW_MAX]     = '0;
    assign valid[WINDOW_MAX]   = 1'b0;

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] left_value;
        logic [IDX_W-1:0]        left_age;
        logic                    left_valid;
        logic                    left_gt;

        if (gi == 0) begin : g_head
            assign left_value = '0;
            assign left_age   = '0;
            assign left_valid = 1'b0;
            assign left_gt    = 1'b0;
        end else begin : g_body
            assign left_value = c_value[gi-1];
            assign left_age   = c_age[gi-1];
            assign left_valid = c_valid[gi-1];
            assign left_gt    = gt[gi-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (IDX_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_sample      (i_sample),
            .i_vkey        (vkey),
            .i_age_last    (i_age_last),
            .i_left_value  (left_value),
            .i_left_age    (left_age),
            .i_left_valid  (left_valid),
            .i_left_gt     (left_gt),
            .i_right_value (value[gi+1]),
            .i_right_age   (age[gi+1]),
            .i_right_valid (valid[gi+1]),
            .o_value       (value[gi]),
            .o_age         (age[gi]),
            .o_valid       (valid[gi]),
            .o_c_value     (c_value[gi]),
            .o_c_age       (c_age[gi]),
            .o_c_valid     (c_valid[gi]),
            .o_gt          (gt[gi]),
            .o_victim      (victim[gi])
        );
    end

    // one-hot selects: ages are distinct, positions are distinct
    always_comb begin
        vkey     = '0;
        o_median = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            vkey     = vkey | (victim[i] ? value[i] : '0);
            o_median = o_median | ((i_mid == IDX_W'(i)) ? value[i] : '0);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/sliding_window_median_unit.sv
// Sliding window median: a result leaves on o_out_valid after its sample transaction
// is taken, via the row update and then the output register. Throughput is one sample
// per cycle, set by the update of the sorted cell row, while o_in_stall is low.
// A result is produced for every sample once window_len samples have arrived.
// Reset (synchronous, active low) sets window_len to 3 and empties the window;
// writing window_len also empties it.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_unit: streaming running median filter
// Keeps the last window_len samples sorted in a row of cells and returns the
// lower median for every sample once the window is full.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [SAMPLE_WIDTH-1:0]      i_sample,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]      o_median,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [swm_pkg::CFG_W-1:0]    i_cfg_window_len
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [swm_pkg::CFG_W-1:0] r_len;
    logic [LEN_W-1:0]          r_fill, n_fill;
    logic                      r_pend, n_pend;
    logic                      r_out_valid;
    logic [SAMPLE_WIDTH-1:0]   r_median;

    logic [LEN_W-1:0]          leff;
    logic [LEN_W-1:0]          fill_inc;
    logic [IDX_W-1:0]          age_last;
    logic [IDX_W-1:0]          mid;
    logic                      accept;
    logic                      drain;
    logic                      cfg_we;
    logic                      produce;
    swm_pkg::t_cell_ctl        ctl;
    logic [SAMPLE_WIDTH-1:0]   chain_median;

    // effective window length, saturated to 1..WINDOW_MAX
    always_comb begin
        if (r_len == '0) begin
            leff = LEN_W'(1);
        end else if (32'(r_len) > 32'(WINDOW_MAX)) begin
            leff = LEN_W'(WINDOW_MAX);
        end else begin
            leff = LEN_W'(r_len);
        end
    end

    assign age_last = IDX_W'(leff - LEN_W'(1));
    assign mid      = IDX_W'((leff - LEN_W'(1)) >> 1);
    assign fill_inc = r_fill + LEN_W'(1);

    assign drain       = r_pend && (!r_out_valid || !i_out_stall);
    // a waiting configuration write goes ahead of the next sample
    assign o_in_stall  = (r_pend && !drain) || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_pend;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    assign ctl.load  = accept;
    assign ctl.evict = accept && (r_fill == leff);
    assign ctl.clear = cfg_we;

    assign produce = ctl.evict || (fill_inc == leff);

    always_comb begin
        n_fill = r_fill;
        if (cfg_we) begin
            n_fill = '0;
        end else if (accept && !ctl.evict) begin
            n_fill = fill_inc;
        end

        n_pend = r_pend;
        if (accept) begin
            n_pend = produce;
        end else if (drain) begin
            n_pend = 1'b0;
        end
    end

    swm_chain #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDX_W        (IDX_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_sample   (i_sample),
        .i_age_last (age_last),
        .i_mid      (mid),
        .o_median   (chain_median)
    );

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_median <= chain_median;
        end
        if (!i_rst_n) begin
            r_len       <= swm_pkg::LEN_RESET;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_len <= i_cfg_window_len;
            end
            r_fill <= n_fill;
            r_pend <= n_pend;
            if (drain) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

    // fill never runs past the window
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= leff)
        else $error("fill count exceeds window length");

    // a pending result always belongs to a full window
    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_fill == leff))
        else $error("pending result with window not full");

    // a new result only appears out of a pending one
    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pend))
        else $error("output valid without pending result");

    // a configuration write empties the window
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> (r_fill == '0))
        else $error("window not emptied after configuration write");

endmodule
`default_nettype wire
